// ----- design/tcs_pkg.sv -----
// shared types, constants and defaults for the text console scrollback block
`default_nettype none

package tcs_pkg;

  localparam int unsigned DEF_HISTORY_LINES = 100;
  localparam int unsigned DEF_SCREEN_ROWS   = 25;
  localparam int unsigned DEF_SCREEN_COLS   = 80;

  localparam logic [7:0] ATTR_RESET   = 8'h07;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [7:0]         char_code;
    logic signed [7:0]  scroll_delta;
    logic [4:0]         view_row;
    logic [6:0]         screen_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [10:0] cursor_position;
    logic [6:0]  view_offset;
    logic [6:0]  lines_used;
  } out_item_t;

  // lookup info carried from the address stage to the result stage
  typedef struct packed {
    cmd_e       command;
    logic       hit;
    logic       is_cur;
    logic [6:0] col;
  } rd_info_t;

  // view state after the item, as reported with every result
  typedef struct packed {
    logic [10:0] cursor_position;
    logic [6:0]  view_offset;
    logic [6:0]  lines_used;
  } status_t;

endpackage

`default_nettype wire

// ----- design/tcs_ram.sv -----
// generic single-port-write, registered-read RAM
`default_nettype none

module tcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/tcs_ctrl.sv -----
// console state, command decode and store address generation
`default_nettype none

module tcs_ctrl import tcs_pkg::*; #(
  parameter int unsigned HISTORY_LINES = DEF_HISTORY_LINES,
  parameter int unsigned SCREEN_ROWS   = DEF_SCREEN_ROWS,
  parameter int unsigned SCREEN_COLS   = DEF_SCREEN_COLS,
  localparam int unsigned AW = $clog2(HISTORY_LINES * SCREEN_COLS),
  localparam int unsigned PW = $clog2(HISTORY_LINES),
  localparam int unsigned CW = $clog2(SCREEN_COLS + 1)
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output logic          store_we_o,
  output logic [AW-1:0] store_addr_o,
  output logic [7:0]    store_wdata_o,
  output logic          len_we_o,
  output logic [PW-1:0] len_addr_o,
  output logic [CW-1:0] len_wdata_o,
  output rd_info_t      rd_info_o,
  output status_t       status_o,
  output logic [CW-1:0] open_len_o
);

  localparam int unsigned LW = $clog2(HISTORY_LINES + 1);
  localparam int unsigned XW = $clog2(HISTORY_LINES + 64 + 1);
  localparam int unsigned SW = ((LW > 8) ? LW : 8) + 2;
  localparam int unsigned QW = XW + 8;

  logic [LW-1:0] total_q, total_d;
  logic [PW-1:0] base_q, base_d;
  logic [LW-1:0] off_q, off_d;
  logic [CW-1:0] cur_q, cur_d;

  logic [XW-1:0] tot_x, used_x, ws_x, log_rd_x, log_cur_x, log_x, maxoff_x, srow_x;
  logic [XW:0]   sum_x;
  logic [PW-1:0] phys;
  logic [6:0]    col_sel;
  logic [AW:0]   addr_full;
  logic [CW:0]   cur_inc;
  logic          open_line;
  logic          hit;
  logic signed [SW-1:0] scroll_v;
  logic [LW-1:0] scroll_clamped;
  logic [QW-1:0] pos_full;

  // window and line addressing
  always_comb begin
    tot_x     = XW'(total_q);
    used_x    = XW'(SCREEN_ROWS) + XW'(off_q);
    ws_x      = (tot_x > used_x) ? (tot_x - used_x) : '0;
    log_rd_x  = ws_x + XW'(item_i.view_row);
    log_cur_x = tot_x - XW'(1);
    log_x     = (item_i.command == CMD_READ) ? log_rd_x : log_cur_x;
    sum_x     = (XW + 1)'(base_q) + (XW + 1)'(log_x);
    phys      = (sum_x >= (XW + 1)'(HISTORY_LINES)) ?
                PW'(sum_x - (XW + 1)'(HISTORY_LINES)) : PW'(sum_x);
    col_sel   = (item_i.command == CMD_READ) ? item_i.screen_col : 7'(cur_q);
    addr_full = (AW + 1)'(phys) * (AW + 1)'(SCREEN_COLS) + (AW + 1)'(col_sel);
    hit       = (32'(item_i.view_row) < SCREEN_ROWS) &&
                (32'(item_i.screen_col) < SCREEN_COLS) &&
                (log_rd_x < tot_x);
    maxoff_x  = (tot_x > XW'(SCREEN_ROWS)) ? (tot_x - XW'(SCREEN_ROWS)) : '0;
  end

  // scroll with saturation
  always_comb begin
    scroll_v = $signed(SW'(off_q)) + SW'($signed(item_i.scroll_delta));
    if (scroll_v < 0) begin
      scroll_clamped = '0;
    end else if (scroll_v > $signed(SW'(maxoff_x))) begin
      scroll_clamped = LW'(maxoff_x);
    end else begin
      scroll_clamped = LW'(scroll_v);
    end
  end

  assign cur_inc = (CW + 1)'(cur_q) + (CW + 1)'(1);

  always_comb begin
    total_d     = total_q;
    base_d      = base_q;
    off_d       = off_q;
    cur_d       = cur_q;
    store_we_o  = 1'b0;
    len_we_o    = 1'b0;
    len_wdata_o = cur_q;
    open_line   = 1'b0;
    if (accept_i) begin
      unique case (item_i.command)
        CMD_PUT: begin
          if (item_i.char_code == NEWLINE_CHAR) begin
            open_line = 1'b1;
            len_we_o  = 1'b1;
          end else begin
            store_we_o = 1'b1;
            if (cur_inc >= (CW + 1)'(SCREEN_COLS)) begin
              open_line   = 1'b1;
              len_we_o    = 1'b1;
              len_wdata_o = CW'(SCREEN_COLS);
            end else begin
              cur_d = CW'(cur_inc);
            end
          end
        end
        CMD_SCROLL: off_d = scroll_clamped;
        CMD_CLEAR: begin
          total_d = LW'(1);
          base_d  = '0;
          off_d   = '0;
          cur_d   = '0;
        end
        CMD_READ: ;
        default: ;
      endcase
    end
    if (open_line) begin
      cur_d = '0;
      if (total_q == LW'(HISTORY_LINES)) begin
        base_d = (base_q == PW'(HISTORY_LINES - 1)) ? '0 : base_q + PW'(1);
      end else begin
        total_d = total_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= LW'(1);
      base_q  <= '0;
      off_q   <= '0;
      cur_q   <= '0;
    end else begin
      total_q <= total_d;
      base_q  <= base_d;
      off_q   <= off_d;
      cur_q   <= cur_d;
    end
  end

  // cursor on screen from the current state
  always_comb begin
    srow_x = tot_x - XW'(1) - ws_x;
    if (srow_x >= XW'(SCREEN_ROWS)) begin
      srow_x = XW'(SCREEN_ROWS - 1);
    end
    if (tot_x < ws_x + XW'(1)) begin
      pos_full = QW'(SCREEN_ROWS * SCREEN_COLS);
    end else begin
      pos_full = QW'(srow_x) * QW'(SCREEN_COLS) + QW'(cur_q);
    end
  end

  assign status_o.cursor_position = 11'(pos_full);
  assign status_o.view_offset     = 7'(off_q);
  assign status_o.lines_used      = 7'(total_q);

  assign store_addr_o  = AW'(addr_full);
  assign store_wdata_o = item_i.char_code;
  assign len_addr_o    = phys;
  assign open_len_o    = cur_q;

  assign rd_info_o.command = item_i.command;
  assign rd_info_o.hit     = hit;
  assign rd_info_o.is_cur  = (log_rd_x == log_cur_x);
  assign rd_info_o.col     = item_i.screen_col;

endmodule

`default_nettype wire

// ----- design/tcs_out.sv -----
// result stage, output register, handshake and attribute register
`default_nettype none

module tcs_out import tcs_pkg::*; #(
  parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS,
  localparam int unsigned CW = $clog2(SCREEN_COLS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               accept_o,
  input  wire logic          text_attribute_we_i,
  input  wire logic [7:0]    text_attribute_i,
  input  wire rd_info_t      rd_info_i,
  input  wire status_t       status_i,
  input  wire logic [CW-1:0] open_len_i,
  input  wire logic [CW-1:0] len_rd_i,
  input  wire logic [7:0]    store_rd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output out_item_t          out_item_o
);

  logic      s2_valid_q;
  rd_info_t  info_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic [7:0] attr_q;
  logic      advance;
  logic      visible;
  logic [7:0] ch;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s2_valid_q || advance;
  assign accept_o   = in_valid_i && in_ready_o;

  always_comb begin
    if (info_q.is_cur) begin
      visible = info_q.hit && (32'(info_q.col) < 32'(open_len_i));
    end else begin
      visible = info_q.hit && (32'(info_q.col) < 32'(len_rd_i));
    end
    ch = visible ? store_rd_i : BLANK_CHAR;
    out_d.cell_value      = (info_q.command == CMD_READ) ? {attr_q, ch} : 16'h0000;
    out_d.cursor_position = status_i.cursor_position;
    out_d.view_offset     = status_i.view_offset;
    out_d.lines_used      = status_i.lines_used;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      attr_q      <= ATTR_RESET;
    end else begin
      if (accept_o) begin
        s2_valid_q <= 1'b1;
      end else if (advance) begin
        s2_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s2_valid_q;
      end
      if (text_attribute_we_i) begin
        attr_q <= text_attribute_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      info_q <= rd_info_i;
    end
    if (advance && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- design/text_console_scrollback.sv -----
// text console with scrollback history, top level
//
// input channel in_valid_i/in_ready_o carries one command item: put character,
// scroll view, clear, or read one cell of the visible window
// output channel out_valid_o/out_ready_i returns one result item per command:
// the cell read (zero for other commands), cursor position, view offset and
// number of lines in use after the command
// text_attribute_we_i/text_attribute_i write the attribute byte, no wait state
// one item per cycle sustained while out_ready_i is high; a result passes the
// registered read of the character store, then the output register
// the character store is one ram written and read at one address per cycle;
// line lengths of closed lines sit in a second small ram, the open line's
// length is the cursor column
// reset empties the history at once, no clearing pass, attribute 0x07
// when the receiver stalls, the output register holds, the result stage can
// still take one item, and in_ready_o drops while both are full
`default_nettype none

module text_console_scrollback import tcs_pkg::*; #(
  parameter int unsigned HISTORY_LINES = DEF_HISTORY_LINES,
  parameter int unsigned SCREEN_ROWS   = DEF_SCREEN_ROWS,
  parameter int unsigned SCREEN_COLS   = DEF_SCREEN_COLS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o,
  input  wire logic       text_attribute_we_i,
  input  wire logic [7:0] text_attribute_i
);

  localparam int unsigned AW = $clog2(HISTORY_LINES * SCREEN_COLS);
  localparam int unsigned PW = $clog2(HISTORY_LINES);
  localparam int unsigned CW = $clog2(SCREEN_COLS + 1);

  logic          accept;
  logic          store_we;
  logic [AW-1:0] store_addr;
  logic [7:0]    store_wdata;
  logic [7:0]    store_rd;
  logic          len_we;
  logic [PW-1:0] len_addr;
  logic [CW-1:0] len_wdata;
  logic [CW-1:0] len_rd;
  logic [CW-1:0] open_len;
  rd_info_t      rd_info;
  status_t       status;

  tcs_ctrl #(
    .HISTORY_LINES(HISTORY_LINES),
    .SCREEN_ROWS  (SCREEN_ROWS),
    .SCREEN_COLS  (SCREEN_COLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .store_we_o   (store_we),
    .store_addr_o (store_addr),
    .store_wdata_o(store_wdata),
    .len_we_o     (len_we),
    .len_addr_o   (len_addr),
    .len_wdata_o  (len_wdata),
    .rd_info_o    (rd_info),
    .status_o     (status),
    .open_len_o   (open_len)
  );

  tcs_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_LINES * SCREEN_COLS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(store_addr),
    .wdata_i(store_wdata),
    .re_i   (accept),
    .raddr_i(store_addr),
    .rdata_o(store_rd)
  );

  tcs_ram #(
    .WIDTH(CW),
    .DEPTH(HISTORY_LINES)
  ) u_len (
    .clk_i  (clk_i),
    .we_i   (len_we),
    .waddr_i(len_addr),
    .wdata_i(len_wdata),
    .re_i   (accept),
    .raddr_i(len_addr),
    .rdata_o(len_rd)
  );

  tcs_out #(
    .SCREEN_COLS(SCREEN_COLS)
  ) u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .accept_o           (accept),
    .text_attribute_we_i(text_attribute_we_i),
    .text_attribute_i   (text_attribute_i),
    .rd_info_i          (rd_info),
    .status_i           (status),
    .open_len_i         (open_len),
    .len_rd_i           (len_rd),
    .store_rd_i         (store_rd),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_item_o         (out_item_o)
  );

endmodule

`default_nettype wire

// ----- design/tcs_chk.sv -----
// port-level checker for the text console scrollback block and its bind
`default_nettype none

module tcs_chk import tcs_pkg::*; #(
  parameter int unsigned HISTORY_LINES = DEF_HISTORY_LINES,
  parameter int unsigned SCREEN_ROWS   = DEF_SCREEN_ROWS,
  parameter int unsigned SCREEN_COLS   = DEF_SCREEN_COLS
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire out_item_t  out_item_o
);

  localparam bit NarrowLines = (HISTORY_LINES < 128);
  localparam bit NarrowPos   = (SCREEN_ROWS * SCREEN_COLS < 2048);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // an accepted item always leaves a result pending once past the result stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("no result two cycles after accept");

  // history always holds the open line, and view offset stays inside it
  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NarrowLines |->
      out_item_o.lines_used != 7'd0 &&
      out_item_o.view_offset < out_item_o.lines_used)
    else $error("view offset outside history");

  // cursor is on screen or hidden
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NarrowPos |->
      32'(out_item_o.cursor_position) <= SCREEN_ROWS * SCREEN_COLS)
    else $error("cursor position beyond screen");

endmodule

bind text_console_scrollback tcs_chk #(
  .HISTORY_LINES(HISTORY_LINES),
  .SCREEN_ROWS  (SCREEN_ROWS),
  .SCREEN_COLS  (SCREEN_COLS)
) u_tcs_chk (.*);

`default_nettype wire
